// ----- sv/ncpd_pkg.sv -----
// ncpd_pkg: shared constants and codes for the nearest constellation point demapper
// no dependencies; used by the top level and its checker
package ncpd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = 2 * COORD_W + 1;
    localparam int ENTRY_W    = 2 * COORD_W;

    localparam logic [CNT_W-1:0]  POINTS_RESET = CNT_W'(4);
    localparam logic [CNT_W-1:0]  POINTS_MAX   = CNT_W'(MAX_POINTS);
    localparam logic [DIST_W-1:0] DIST_INF     = '1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_DEMAP = 1'b1
    } op_t;

endpackage

// ----- sv/nearest_constellation_point_demapper_unit.sv -----
// nearest_constellation_point_demapper_unit: table-based minimum distance demapper
// depends on ncpd_pkg
// a load word writes one point table entry; a demap word scans n points, from acceptance
// to a registered result, one table read per cycle from the point memory
// the next word is accepted the cycle after the result is registered, even if it waits
// reset clears control state and sets points_in_use to 4; the point table is not cleared
module nearest_constellation_point_demapper_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ncpd_pkg::CNT_W-1:0]            cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [ncpd_pkg::IDX_W-1:0]            point_index,
    input  logic signed [ncpd_pkg::COORD_W-1:0]   point_i,
    input  logic signed [ncpd_pkg::COORD_W-1:0]   point_q,
    input  logic signed [ncpd_pkg::COORD_W-1:0]   sample_in_phase,
    input  logic signed [ncpd_pkg::COORD_W-1:0]   sample_quadrature,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ncpd_pkg::IDX_W-1:0]            symbol,
    output logic [ncpd_pkg::DIST_W-1:0]           best_distance,
    output logic [ncpd_pkg::DIST_W-1:0]           second_distance
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic [ncpd_pkg::CNT_W-1:0] points_in_use_reg;

    logic [ncpd_pkg::ENTRY_W-1:0] mem [ncpd_pkg::MAX_POINTS];
    logic [ncpd_pkg::ENTRY_W-1:0] rd_data_reg;

    logic [ncpd_pkg::IDX_W-1:0] addr_reg;
    logic [ncpd_pkg::IDX_W-1:0] last_addr_reg;
    logic signed [ncpd_pkg::COORD_W-1:0] si_reg;
    logic signed [ncpd_pkg::COORD_W-1:0] sq_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic last1_reg, last2_reg, last3_reg;
    logic [ncpd_pkg::IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg;

    logic signed [ncpd_pkg::DIFF_W-1:0] di_reg, dq_reg;
    logic [ncpd_pkg::SQ_W-1:0] sqi_reg, sqq_reg;

    logic seen_reg;
    logic [ncpd_pkg::IDX_W-1:0]  best_sym_reg;
    logic [ncpd_pkg::DIST_W-1:0] best_reg, second_reg;

    logic out_valid_reg;
    logic [ncpd_pkg::IDX_W-1:0]  symbol_reg;
    logic [ncpd_pkg::DIST_W-1:0] nearest_reg, next_reg;

    logic in_accept;
    logic op_is_demap;
    logic [ncpd_pkg::CNT_W-1:0] npts;
    logic [ncpd_pkg::CNT_W-1:0] npts_m1;
    logic rd_issue;
    logic signed [ncpd_pkg::DIFF_W-1:0] di_next, dq_next;
    logic signed [2*ncpd_pkg::DIFF_W-1:0] sqi_full, sqq_full;
    logic [ncpd_pkg::DIST_W-1:0] cand_dist;
    logic out_free;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign op_is_demap = (op == ncpd_pkg::OP_DEMAP);
    assign npts        = (points_in_use_reg > ncpd_pkg::POINTS_MAX) ? ncpd_pkg::POINTS_MAX
                                                                     : points_in_use_reg;
    assign npts_m1     = npts - ncpd_pkg::CNT_W'(1);
    assign rd_issue    = (state_reg == ST_SCAN);
    assign out_free    = !out_valid_reg || !out_stall;

    assign di_next = ncpd_pkg::DIFF_W'(si_reg)
                   - ncpd_pkg::DIFF_W'($signed(rd_data_reg[ncpd_pkg::ENTRY_W-1:ncpd_pkg::COORD_W]));
    assign dq_next = ncpd_pkg::DIFF_W'(sq_reg)
                   - ncpd_pkg::DIFF_W'($signed(rd_data_reg[ncpd_pkg::COORD_W-1:0]));
    assign sqi_full  = di_reg * di_reg;
    assign sqq_full  = dq_reg * dq_reg;
    assign cand_dist = ncpd_pkg::DIST_W'(sqi_reg) + ncpd_pkg::DIST_W'(sqq_reg);

    assign out_valid       = out_valid_reg;
    assign symbol          = symbol_reg;
    assign best_distance   = nearest_reg;
    assign second_distance = next_reg;

    // point memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (in_accept && !op_is_demap)
        begin
            mem[point_index] <= {point_i, point_q};
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // distance datapath
    always_ff @(posedge clk)
    begin
        if (in_accept && op_is_demap)
        begin
            si_reg        <= sample_in_phase;
            sq_reg        <= sample_quadrature;
            last_addr_reg <= npts_m1[ncpd_pkg::IDX_W-1:0];
        end
        idx1_reg  <= addr_reg;
        last1_reg <= (addr_reg == last_addr_reg);
        idx2_reg  <= idx1_reg;
        last2_reg <= last1_reg;
        di_reg    <= di_next;
        dq_reg    <= dq_next;
        idx3_reg  <= idx2_reg;
        last3_reg <= last2_reg;
        sqi_reg   <= sqi_full[ncpd_pkg::SQ_W-1:0];
        sqq_reg   <= sqq_full[ncpd_pkg::SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            points_in_use_reg <= ncpd_pkg::POINTS_RESET;
            addr_reg          <= '0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            seen_reg          <= 1'b0;
            best_sym_reg      <= '0;
            best_reg          <= ncpd_pkg::DIST_INF;
            second_reg        <= ncpd_pkg::DIST_INF;
            out_valid_reg     <= 1'b0;
            symbol_reg        <= '0;
            nearest_reg       <= '0;
            next_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                points_in_use_reg <= cfg_wdata;
            end

            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            v1_reg <= rd_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            // running best and second best
            if (v3_reg)
            begin
                if (!seen_reg || cand_dist < best_reg)
                begin
                    if (seen_reg)
                    begin
                        second_reg <= best_reg;
                    end
                    best_reg     <= cand_dist;
                    best_sym_reg <= idx3_reg;
                    seen_reg     <= 1'b1;
                end
                else if (cand_dist < second_reg)
                begin
                    second_reg <= cand_dist;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && op_is_demap)
                    begin
                        addr_reg     <= '0;
                        seen_reg     <= 1'b0;
                        best_sym_reg <= '0;
                        best_reg     <= ncpd_pkg::DIST_INF;
                        second_reg   <= ncpd_pkg::DIST_INF;
                        state_reg    <= (npts == '0) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    addr_reg <= addr_reg + ncpd_pkg::IDX_W'(1);
                    if (addr_reg == last_addr_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (v3_reg && last3_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        symbol_reg    <= best_sym_reg;
                        nearest_reg   <= best_reg;
                        next_reg      <= second_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/ncpd_checker.sv -----
// ncpd_checker: port-level assertions for the demapper, bound to the top level
// depends on ncpd_pkg and nearest_constellation_point_demapper_unit
module ncpd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                op,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [ncpd_pkg::IDX_W-1:0]          symbol,
    input logic [ncpd_pkg::DIST_W-1:0]         best_distance,
    input logic [ncpd_pkg::DIST_W-1:0]         second_distance
);

    // held result word keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol)
            && $stable(best_distance) && $stable(second_distance))
        else $error("stalled result word changed");

    // second distance never below the best one
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> second_distance >= best_distance)
        else $error("second distance below best distance");

    // a demap word occupies the block
    a_demap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == ncpd_pkg::OP_DEMAP |=> in_stall)
        else $error("demap word accepted without going busy");

    // a load word leaves the block free to accept the next word
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == ncpd_pkg::OP_LOAD |=> !in_stall)
        else $error("load word left the block busy");

endmodule

bind nearest_constellation_point_demapper_unit ncpd_checker u_ncpd_checker (.*);
